FILE: rtl/core/cfr_pkg.sv
package cfr_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CODE        = 3'd0,
    REG_READ_TYPE         = 3'd1,
    REG_WRITE_TYPE        = 3'd2,
    REG_BLOCK_CONFIG_TYPE = 3'd3,
    REG_BLOCK_READ_TYPE   = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [7:0] START_CODE_RST        = 8'd2;
  localparam logic [7:0] READ_TYPE_RST         = 8'd0;
  localparam logic [7:0] WRITE_TYPE_RST        = 8'd1;
  localparam logic [7:0] BLOCK_CONFIG_TYPE_RST = 8'd2;
  localparam logic [7:0] BLOCK_READ_TYPE_RST   = 8'd3;

  // Frame layout
  localparam logic [9:0] HDR_BYTES = 10'd2;
  localparam logic [9:0] TRL_BYTES = 10'd2;

  // CRC-16 generator polynomial, MSB first
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] read_type;
    logic [7:0] write_type;
    logic [7:0] block_config_type;
    logic [7:0] block_read_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_kind;
    logic [7:0] item_count;
    logic [7:0] first_payload;
    logic       status;
  } result_t;

  // One byte through the CRC register, eight shifts unrolled
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/cfr_if.sv
// Received byte channel
interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Frame result channel
interface cfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_kind;
  logic [7:0] item_count;
  logic [7:0] first_payload;
  logic       status;

  modport source (output valid, output frame_kind, output item_count,
                  output first_payload, output status, input ready);
  modport sink (input valid, input frame_kind, input item_count,
                input first_payload, input status, output ready);
endinterface

// Register write channel
interface cfr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cfr_pkg::CFG_IDX_W-1:0] reg_index;
  logic [7:0]                     wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: rtl/core/cfr_cfg_regs.sv
module cfr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [cfr_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]                     wr_data,
  output cfr_pkg::cfg_t                  cfg
);

  cfr_pkg::cfg_t cfg_r;
  cfr_pkg::cfg_t cfg_nxt;

  // Decode the write; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfr_pkg::cfg_reg_t'(wr_index))
        cfr_pkg::REG_START_CODE:        cfg_nxt.start_code = wr_data;
        cfr_pkg::REG_READ_TYPE:         cfg_nxt.read_type = wr_data;
        cfr_pkg::REG_WRITE_TYPE:        cfg_nxt.write_type = wr_data;
        cfr_pkg::REG_BLOCK_CONFIG_TYPE: cfg_nxt.block_config_type = wr_data;
        cfr_pkg::REG_BLOCK_READ_TYPE:   cfg_nxt.block_read_type = wr_data;
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code        <= cfr_pkg::START_CODE_RST;
      cfg_r.read_type         <= cfr_pkg::READ_TYPE_RST;
      cfg_r.write_type        <= cfr_pkg::WRITE_TYPE_RST;
      cfg_r.block_config_type <= cfr_pkg::BLOCK_CONFIG_TYPE_RST;
      cfg_r.block_read_type   <= cfr_pkg::BLOCK_READ_TYPE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/cfr_parser.sv
module cfr_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  cfr_pkg::cfg_t    cfg,
  input  logic             take,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output cfr_pkg::result_t res
);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_HEADER,
    ST_DATA,
    ST_TRAILER
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  prev_r, prev_nxt;

  logic [8:0]  cnt_inc;
  logic [15:0] crc_upd;
  logic [7:0]  len_type;
  logic [9:0]  data_end;
  logic [9:0]  frame_end;

  // Saturating byte count
  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 9'd1;
  assign crc_upd = cfr_pkg::crc16_byte(crc_r, rx_byte);

  // Payload length from the frame type, first match wins
  always_comb begin
    priority if (type_r == cfg.read_type)         len_type = 8'd1;
    else if (type_r == cfg.write_type)        len_type = 8'd1 + {count_r[6:0], 1'b0};
    else if (type_r == cfg.block_config_type) len_type = count_r;
    else if (type_r == cfg.block_read_type)   len_type = 8'd1;
    else                                      len_type = 8'd0;
  end

  assign data_end  = cfr_pkg::HDR_BYTES + {2'b00, len_type};
  assign frame_end = cfr_pkg::HDR_BYTES + {2'b00, len_r} + cfr_pkg::TRL_BYTES;

  // Next state for one accepted byte
  always_comb begin
    state_nxt = state_r;
    crc_nxt   = crc_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    count_nxt = count_r;
    first_nxt = first_r;
    prev_nxt  = prev_r;
    res_valid = 1'b0;
    if (take) begin
      prev_nxt = rx_byte;
      unique case (state_r)
        ST_HUNT: begin
          if (rx_byte == cfg.start_code) begin
            state_nxt = ST_HEADER;
            crc_nxt   = '0;
            cnt_nxt   = '0;
            len_nxt   = '0;
          end
        end
        ST_HEADER: begin
          if (cnt_r == '0) type_nxt = rx_byte;
          else count_nxt = rx_byte;
          cnt_nxt = cnt_inc;
          crc_nxt = crc_upd;
          if ({1'b0, cnt_inc} >= cfr_pkg::HDR_BYTES) state_nxt = ST_DATA;
        end
        ST_DATA: begin
          if ({1'b0, cnt_r} == cfr_pkg::HDR_BYTES) first_nxt = rx_byte;
          cnt_nxt = cnt_inc;
          crc_nxt = crc_upd;
          len_nxt = len_type;
          if ({1'b0, cnt_inc} >= data_end) state_nxt = ST_TRAILER;
        end
        ST_TRAILER: begin
          cnt_nxt = cnt_inc;
          if ({1'b0, cnt_inc} >= frame_end) begin
            res_valid = 1'b1;
            state_nxt = ST_HUNT;
          end
        end
      endcase
    end
  end

  // Trailer is the previous byte and this one, big-endian
  assign res.frame_kind    = type_r;
  assign res.item_count    = count_r;
  assign res.first_payload = first_r;
  assign res.status        = ({prev_r, rx_byte} != crc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      cnt_r   <= '0;
      len_r   <= '0;
      crc_r   <= '0;
      prev_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      prev_r  <= prev_nxt;
    end
  end

  // Header and payload captures are always written before use
  always_ff @(posedge clk) begin
    type_r  <= type_nxt;
    count_r <= count_nxt;
    first_r <= first_nxt;
  end

endmodule

FILE: rtl/core/cfr_out_reg.sv
module cfr_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  cfr_pkg::result_t res_in,
  input  logic             out_ready,
  output logic             out_valid,
  output cfr_pkg::result_t res_out,
  output logic             space
);

  logic             valid_r, valid_nxt;
  cfr_pkg::result_t data_r, data_nxt;

  // Room for a new result when empty or draining this cycle
  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = res_in;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign res_out   = data_r;

endmodule

FILE: rtl/core/crc_checked_frame_receiver.sv
// Frame receiver with CRC-16/XMODEM check. One received byte is taken per clock
// cycle, with no gaps needed between bytes: the byte parser updates its phase,
// counters and CRC as each byte is taken. A frame result appears on the output
// in the cycle after the transfer of the last trailer byte and is held in the
// output register until taken. The input stalls only while that register holds a
// result and the output side is not ready. Registers are written through the cfg
// channel, which is always ready; write them only while no frame is in progress.
module crc_checked_frame_receiver (
  input  logic      clk,
  input  logic      rst_n,
  cfr_in_if.sink    in_ch,
  cfr_out_if.source out_ch,
  cfr_cfg_if.sink   cfg_ch
);

  cfr_pkg::cfg_t    cfg;
  cfr_pkg::result_t res;
  cfr_pkg::result_t res_q;
  logic             res_valid;
  logic             space;
  logic             in_take;

  // Register writes complete every cycle
  assign cfg_ch.ready = 1'b1;

  cfr_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.reg_index),
    .wr_data  (cfg_ch.wdata),
    .cfg      (cfg)
  );

  // Accept a byte whenever the output register can take a result
  assign in_ch.ready = space;
  assign in_take     = in_ch.valid && space;

  cfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .take      (in_take),
    .rx_byte   (in_ch.rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  cfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res_in    (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .res_out   (res_q),
    .space     (space)
  );

  assign out_ch.frame_kind    = res_q.frame_kind;
  assign out_ch.item_count    = res_q.item_count;
  assign out_ch.first_payload = res_q.first_payload;
  assign out_ch.status        = res_q.status;

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_ch.valid || out_ch.ready))
    else $error("result loaded over a pending result");

  // A result comes only from an accepted byte
  a_result_from_take: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_take)
    else $error("result without an accepted byte");

  // A drained output with no new result goes empty
  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !res_valid) |=> !out_ch.valid)
    else $error("output stays valid after its transfer");

endmodule
